@@ hw/rtl/pcache_pkg.sv @@
// Shared types and constants for the presence cache with miss TTL.
package pcache_pkg;

    localparam int KEY_W       = 32;
    localparam int TICK_W      = 32;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 32;
    localparam logic [TICK_W-1:0] TTL_RESET = 32'd5000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_BYPASS
    } t_state;

    typedef enum logic [1:0] {
        FIN_BYPASS,
        FIN_HIT,
        FIN_MISS
    } t_fin;

    typedef struct packed {
        logic load_in;
        logic start;
        logic step;
        logic finish;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic              present;
        logic [TICK_W-1:0] tick;
        logic [KEY_W-1:0]  key;
    } t_entry;

endpackage

@@ hw/rtl/presence_cache_with_miss_ttl.sv @@
// Top level of the presence cache with miss TTL.
//
//  channel   dir  payload (low bit first)
//  s_axis    in   tdata: source_key, fallback_key, now_tick, probe_present, pad
//                 tuser: is_file_source
//  m_axis    out  tdata: chosen_key; tuser: probe_used
//  cfg       in   data: miss_ttl_ticks
//
// An item that bypasses the table is finished without a scan; any other item is scanned:
// one slot of the entry memory is read per cycle, up to the fill count.
// Synchronous active-low reset empties the table and loads a TTL of 5000.
// A result waits in the output register; the next item is accepted meanwhile,
// and only its final write of a result waits for m_axis_tready.
module presence_cache_with_miss_ttl #(
    parameter int SLOTS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcache_pkg::TICK_W-1:0]        i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // source_key[31:0], fallback_key[63:32], now_tick[95:64], probe_present[96]
    input  logic [pcache_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // is_file_source
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // chosen_key[31:0]
    output logic [pcache_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // probe_used
    output logic                                 m_axis_tuser
);
    import pcache_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pcache_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    pcache_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser)
    );

endmodule

@@ hw/rtl/pcache_ctrl.sv @@
// Sequencer for the presence cache: accept, classify, scan, finish.
module pcache_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  pcache_pkg::t_stat i_stat,
    output pcache_pkg::t_cmd  o_cmd
);
    import pcache_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_CLASS;
            end
            S_CLASS: begin
                n_state = i_stat.bypass ? S_BYPASS : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) n_state = S_HIT;
                else if (i_stat.scan_end) n_state = S_MISS;
            end
            S_HIT, S_MISS, S_BYPASS: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready    = 1'b0;
        o_cmd        = '0;
        o_cmd.fin    = FIN_BYPASS;
        case (r_state)
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
                o_cmd.start   = i_s_valid;
            end
            S_CLASS: begin
                o_cmd.step = !i_stat.bypass;
            end
            S_SCAN: begin
                o_cmd.step = !i_stat.hit && !i_stat.scan_end;
            end
            S_HIT: begin
                o_cmd.finish = i_stat.out_free;
                o_cmd.fin    = FIN_HIT;
            end
            S_MISS: begin
                o_cmd.finish = i_stat.out_free;
                o_cmd.fin    = FIN_MISS;
            end
            S_BYPASS: begin
                o_cmd.finish = i_stat.out_free;
                o_cmd.fin    = FIN_BYPASS;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    a_accept_to_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_valid) |=> (r_state == S_CLASS))
        else $error("accepted beat did not move to classify");

    a_hit_to_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.hit) |=> (r_state == S_HIT))
        else $error("scan hit not followed by hit state");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("finish issued while output register busy");

endmodule

@@ hw/rtl/pcache_dp.sv @@
// Datapath: item latch, entry memory, scan pipe, decision and output register.
module pcache_dp #(
    parameter int SLOTS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [pcache_pkg::TICK_W-1:0]        i_cfg_data,
    input  logic [pcache_pkg::IN_DATA_W-1:0]     i_s_data,
    input  logic                                 i_s_user,
    input  pcache_pkg::t_cmd                     i_cmd,
    output pcache_pkg::t_stat                    o_stat,
    output logic                                 o_m_valid,
    input  logic                                 i_m_ready,
    output logic [pcache_pkg::OUT_DATA_W-1:0]    o_m_data,
    output logic                                 o_m_user
);
    import pcache_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_fb;
    logic              r_file;
    logic [TICK_W-1:0] r_now;
    logic              r_probe;
    logic [TICK_W-1:0] r_ttl;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_cmp_idx;
    logic              r_cmp_live;
    t_entry            r_rd;
    t_entry            r_mem [SLOTS];
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_out_key;
    logic              r_out_used;

    logic [TICK_W-1:0] age;
    logic              fresh;
    logic [KEY_W-1:0]  probe_key;
    logic [KEY_W-1:0]  n_out_key;
    logic              n_out_used;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              fill;
    t_entry            wr_data;

    assign age       = r_now - r_rd.tick;
    assign fresh     = age < r_ttl;
    assign probe_key = r_probe ? r_key : r_fb;

    assign o_stat.bypass   = (r_key == '0) || !r_file;
    assign o_stat.hit      = r_cmp_live && (r_rd.key == r_key);
    assign o_stat.scan_end = !r_cmp_live;
    assign o_stat.out_free = !r_out_valid || i_m_ready;

    assign wr_data.key     = r_key;
    assign wr_data.tick    = r_now;
    assign wr_data.present = r_probe;

    always_comb begin
        n_out_key  = probe_key;
        n_out_used = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = r_cmp_idx[IW-1:0];
        fill       = 1'b0;
        case (i_cmd.fin)
            FIN_BYPASS: begin
                n_out_key  = (r_key == '0) ? r_fb : r_key;
                n_out_used = 1'b0;
            end
            FIN_HIT: begin
                if (r_rd.present) begin
                    n_out_key  = r_key;
                    n_out_used = 1'b0;
                end else if (fresh) begin
                    n_out_key  = r_fb;
                    n_out_used = 1'b0;
                end else begin
                    wr_en = i_cmd.finish;
                end
            end
            FIN_MISS: begin
                wr_addr = r_count[IW-1:0];
                fill    = i_cmd.finish && (r_count < CW'(SLOTS));
                wr_en   = fill;
            end
            default: begin
                n_out_used = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key   <= i_s_data[31:0];
            r_fb    <= i_s_data[63:32];
            r_now   <= i_s_data[95:64];
            r_probe <= i_s_data[96];
            r_file  <= i_s_user;
        end
        if (i_cmd.step) begin
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.finish) begin
            r_out_key  <= n_out_key;
            r_out_used <= n_out_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl       <= TTL_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_ttl <= i_cfg_data;
            if (fill) r_count <= r_count + CW'(1);
            if (i_cmd.start) begin
                r_idx      <= '0;
                r_cmp_live <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx      <= r_idx + CW'(1);
                r_cmp_live <= r_idx < r_count;
            end
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (i_m_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) r_rd <= r_mem[r_idx[IW-1:0]];
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_key;
    assign o_m_user  = r_out_used;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("fill count beyond table size");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("fill count went backwards");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item not in output register");

endmodule
